### rtl/ftgr_pkg.sv
// Shared types and constants of the text line glyph renderer.
package ftgr_pkg;

	// Item kinds carried on the input tuser
	localparam logic [1:0] CMD_FONT  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_CHAR  = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_BOLD_ON  = 3'd0;
	localparam logic [2:0] REG_BOLD_OFF = 3'd1;
	localparam logic [2:0] REG_DECIMAL  = 3'd2;
	localparam logic [2:0] REG_HEX_WORD = 3'd3;
	localparam logic [2:0] REG_HEX_BYTE = 3'd4;

	localparam int GLYPH_ROWS = 8;
	localparam int ROW_BITS   = 3;
	localparam int OFFSET_W   = 13;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 24;

	// Controller to datapath
	typedef struct packed {
		logic accept;   // input transaction this cycle
		logic issue;    // read one glyph row and advance the render counters
	} ftgr_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic render_start; // accepted item draws at least one glyph
		logic advance;      // output stage can move this cycle
		logic row_last;     // current glyph row is the final one
		logic glyph_last;   // current glyph is the final one of the item
	} ftgr_status_t;

endpackage

### rtl/ftgr_ctrl.sv
// Controller state machine: input handshake and render sequencing.
module ftgr_ctrl
	import ftgr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  ftgr_status_t status,
	output ftgr_cmd_t    cmd
);

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_RENDER = 1'b1;

	logic state_q;
	logic state_d;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cmd.accept    = s_axis_tvalid && (state_q == ST_IDLE);
	assign cmd.issue     = (state_q == ST_RENDER) && status.advance;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept && status.render_start)
					state_d = ST_RENDER;
			end
			ST_RENDER: begin
				if (cmd.issue && status.row_last && status.glyph_last)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

### rtl/ftgr_datapath.sv
// Datapath: config registers, glyph store, cursor, glyph list and output stage.
module ftgr_datapath
	import ftgr_pkg::*;
#(
	parameter int ROW_CHARS  = 32,
	parameter int FONT_CHARS = 96
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [2:0]            cfg_addr,
	input  logic [7:0]            cfg_wdata,
	input  logic [1:0]            in_kind,
	input  logic [IN_DATA_W-1:0]  in_data,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast,
	input  ftgr_cmd_t             cmd,
	output ftgr_status_t          status
);

	localparam int STORE = FONT_CHARS * GLYPH_ROWS;
	localparam int AW    = $clog2(STORE);
	localparam int CW    = (ROW_CHARS >= 32) ? $clog2(ROW_CHARS + 1) : 6;

	// Input fields
	logic [9:0] font_index;
	logic [7:0] font_byte;
	logic [4:0] text_row;
	logic [4:0] start_column;
	logic [7:0] character_code;
	logic [7:0] arg_low;
	logic [7:0] arg_high;

	assign font_index     = in_data[9:0];
	assign font_byte      = in_data[17:10];
	assign text_row       = in_data[22:18];
	assign start_column   = in_data[27:23];
	assign character_code = in_data[35:28];
	assign arg_low        = in_data[43:36];
	assign arg_high       = in_data[51:44];

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h61 + {4'd0, nib} - 8'd10);
	endfunction

	// Configuration registers
	logic [7:0] bold_on_q, bold_off_q, dec_code_q, hexw_code_q, hexb_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bold_on_q   <= 8'd1;
			bold_off_q  <= 8'd2;
			dec_code_q  <= 8'd3;
			hexw_code_q <= 8'd4;
			hexb_code_q <= 8'd5;
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_BOLD_ON:  bold_on_q   <= cfg_wdata;
				REG_BOLD_OFF: bold_off_q  <= cfg_wdata;
				REG_DECIMAL:  dec_code_q  <= cfg_wdata;
				REG_HEX_WORD: hexw_code_q <= cfg_wdata;
				REG_HEX_BYTE: hexb_code_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Decimal digits of arg_low: hundreds by compare, tens by reciprocal multiply
	logic [1:0]  dec_h;
	logic [7:0]  dec_sub;
	logic [6:0]  dec_rem;
	logic [14:0] dec_prod;
	logic [3:0]  dec_t;
	logic [6:0]  dec_tx10;
	logic [3:0]  dec_o;

	always_comb begin
		if (arg_low >= 8'd200) begin
			dec_h   = 2'd2;
			dec_sub = 8'd200;
		end else if (arg_low >= 8'd100) begin
			dec_h   = 2'd1;
			dec_sub = 8'd100;
		end else begin
			dec_h   = 2'd0;
			dec_sub = 8'd0;
		end
		dec_rem  = 7'(arg_low - dec_sub);
		dec_prod = 15'({8'd0, dec_rem} * 15'd205);
		dec_t    = dec_prod[14:11];
		dec_tx10 = 7'({3'd0, dec_t} * 7'd10);
		dec_o    = 4'(dec_rem - dec_tx10);
	end

	// Render state
	logic [OFFSET_W-1:0] cursor_q;
	logic [CW-1:0]       column_q;
	logic                bold_q;
	logic [7:0]          codes_q [4];
	logic [1:0]          last_gi_q;
	logic [1:0]          gi_q;
	logic [ROW_BITS-1:0] row_q;

	logic line_open;
	logic is_char;
	assign is_char   = cmd.accept && (in_kind == CMD_CHAR);
	assign line_open = (column_q < CW'(ROW_CHARS));

	assign status.render_start = (in_kind == CMD_CHAR) && line_open
		&& (character_code != bold_on_q) && (character_code != bold_off_q);
	assign status.row_last   = (row_q == ROW_BITS'(GLYPH_ROWS - 1));
	assign status.glyph_last = (gi_q == last_gi_q) || (column_q == CW'(ROW_CHARS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q  <= '0;
			column_q  <= CW'(ROW_CHARS);
			bold_q    <= 1'b0;
			last_gi_q <= '0;
			gi_q      <= '0;
			row_q     <= '0;
		end else if (cmd.accept && (in_kind == CMD_START)) begin
			cursor_q <= {text_row[4:3], 3'd0, text_row[2:0], start_column};
			column_q <= CW'(start_column);
			bold_q   <= 1'b0;
		end else if (is_char && line_open) begin
			gi_q  <= '0;
			row_q <= '0;
			if (character_code == bold_on_q)
				bold_q <= 1'b1;
			else if (character_code == bold_off_q)
				bold_q <= 1'b0;
			else if (character_code == dec_code_q)
				last_gi_q <= (dec_h != 2'd0) ? 2'd2 : (dec_t != 4'd0) ? 2'd1 : 2'd0;
			else if (character_code == hexw_code_q)
				last_gi_q <= 2'd3;
			else if (character_code == hexb_code_q)
				last_gi_q <= 2'd1;
			else
				last_gi_q <= 2'd0;
		end else if (cmd.issue) begin
			row_q <= row_q + 1'b1;
			if (status.row_last) begin
				cursor_q <= cursor_q + 1'b1;
				column_q <= column_q + 1'b1;
				gi_q     <= gi_q + 1'b1;
			end
		end
	end

	// Glyph code list, no reset needed
	always_ff @(posedge clk) begin
		if (is_char && line_open) begin
			if (character_code == dec_code_q) begin
				if (dec_h != 2'd0) begin
					codes_q[0] <= 8'h30 + {6'd0, dec_h};
					codes_q[1] <= 8'h30 + {4'd0, dec_t};
					codes_q[2] <= 8'h30 + {4'd0, dec_o};
				end else if (dec_t != 4'd0) begin
					codes_q[0] <= 8'h30 + {4'd0, dec_t};
					codes_q[1] <= 8'h30 + {4'd0, dec_o};
				end else begin
					codes_q[0] <= 8'h30 + {4'd0, dec_o};
				end
			end else if (character_code == hexw_code_q) begin
				codes_q[0] <= hex_char(arg_high[7:4]);
				codes_q[1] <= hex_char(arg_high[3:0]);
				codes_q[2] <= hex_char(arg_low[7:4]);
				codes_q[3] <= hex_char(arg_low[3:0]);
			end else if (character_code == hexb_code_q) begin
				codes_q[0] <= hex_char(arg_low[7:4]);
				codes_q[1] <= hex_char(arg_low[3:0]);
			end else begin
				codes_q[0] <= character_code;
			end
		end
	end

	// Glyph store
	logic [7:0]  store [STORE];
	logic [7:0]  rd_q;
	logic [7:0]  cur_code;
	logic [7:0]  code_off;
	logic        known;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic        wr_en;

	assign cur_code = codes_q[gi_q];
	assign code_off = cur_code - 8'd32;
	assign known    = (cur_code >= 8'd32) && ({1'b0, code_off} < 9'(FONT_CHARS));
	assign rd_addr  = AW'({code_off, row_q});
	assign wr_addr  = AW'({1'b0, font_index});
	assign wr_en    = cmd.accept && (in_kind == CMD_FONT) && ({1'b0, font_index} < 11'(STORE));

	always_ff @(posedge clk) begin
		if (wr_en)
			store[wr_addr] <= font_byte;
		if (cmd.issue)
			rd_q <= store[rd_addr];
	end

	// Read stage and output register; hold both while the output stalls
	logic                valid_s1;
	logic [OFFSET_W-1:0] off_s1;
	logic                last_s1;
	logic                known_s1;
	logic                bold_s1;
	logic                out_valid_q;
	logic [OFFSET_W-1:0] out_off_q;
	logic [7:0]          out_byte_q;
	logic                out_last_q;
	logic [7:0]          px;

	assign status.advance = !out_valid_q || m_axis_tready;
	assign px = known_s1 ? (bold_s1 ? (rd_q | (rd_q >> 1)) : rd_q) : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (status.advance) begin
			valid_s1    <= cmd.issue;
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (status.advance) begin
			off_s1     <= cursor_q + OFFSET_W'({row_q, 8'd0});
			last_s1    <= status.row_last && status.glyph_last;
			known_s1   <= known;
			bold_s1    <= bold_q;
			out_off_q  <= off_s1;
			out_byte_q <= px;
			out_last_q <= last_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, out_byte_q, out_off_q};
	assign m_axis_tlast  = out_last_q;

endmodule

### rtl/formatted_text_glyph_render.sv
// A character item that draws puts the controller in render; each issued glyph row goes
// from the glyph store read through the read stage to the output register. Input is not
// ready while an item renders. A character item draws up to 4 glyphs, one store read per
// cycle unless the output stalls; a stall holds the read stage and render counters. Reset
// (arst_n, async, active low) clears control state and cursor, presets column and config
// registers; the glyph store is not cleared and holds nothing useful until written.
module formatted_text_glyph_render
	import ftgr_pkg::*;
#(
	parameter int ROW_CHARS  = 32,
	parameter int FONT_CHARS = 96
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [2:0]            cfg_addr,
	input  logic [7:0]            cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// font_index[9:0], font_byte[17:10], text_row[22:18], start_column[27:23],
	// character_code[35:28], arg_low[43:36], arg_high[51:44], zero fill
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// cmd[1:0]
	input  logic [1:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// pixel_offset[12:0], pixel_byte[20:13], zero fill
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast
);

	ftgr_cmd_t    cmd;
	ftgr_status_t status;

	ftgr_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.status        (status),
		.cmd           (cmd)
	);

	ftgr_datapath #(
		.ROW_CHARS  (ROW_CHARS),
		.FONT_CHARS (FONT_CHARS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.in_kind       (s_axis_tuser),
		.in_data       (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cmd           (cmd),
		.status        (status)
	);

endmodule

### verif/ftgr_pixel_checker.sv
// Scoreboard for the glyph renderer: predicts every pixel write and checks the output stream.
module ftgr_pixel_checker
	import ftgr_pkg::*;
#(
	parameter int          ROW_CHARS     = 32,
	parameter int          FONT_CHARS    = 96,
	parameter logic [39:0] DEFAULT_CODES = '0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [2:0]            cfg_addr,
	input  logic [7:0]            cfg_wdata,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	// font_index, font_byte, text_row, start_column, character_code, arg_low, arg_high
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// cmd
	input  logic [1:0]            s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// pixel_offset, pixel_byte
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  m_axis_tlast,
	output int                    mismatches,
	output int                    pending
);
	localparam int         STORE_DEPTH = FONT_CHARS * GLYPH_ROWS;
	localparam int         REG_COUNT   = int'(REG_HEX_BYTE) + 1;
	localparam int         ROW_STRIDE  = 'h0100;
	localparam logic [7:0] FIRST_GLYPH = 8'd32;
	localparam logic [7:0] CHAR_ZERO   = "0";
	localparam logic [7:0] CHAR_A      = "a";

	typedef struct packed {
		logic [OFFSET_W-1:0] offset;
		logic [7:0]          pixels;
		logic                last;
	} pixel_write_t;

	pixel_write_t        pixel_queue[$];
	logic [7:0]          glyph_mem [STORE_DEPTH];
	logic [7:0]          codes [REG_COUNT];
	logic [OFFSET_W-1:0] cursor;
	int                  column;
	logic                bold;
	int                  drawn;
	int                  checked;

	function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
		return (nibble < 4'd10) ? CHAR_ZERO + 8'(nibble) : CHAR_A + 8'(nibble) - 8'd10;
	endfunction

	task automatic log_mismatch(input string msg);
		$display("[%0t] pixel write %0d: %s", $time, checked, msg);
		mismatches++;
	endtask

	// Queue the eight row writes of one glyph at the cursor, then advance.
	task automatic draw_glyph(input logic [7:0] code);
		int           base;
		int           r;
		bit           known;
		logic [7:0]   px;
		pixel_write_t w;
		if (column >= ROW_CHARS) return;
		known = (code >= FIRST_GLYPH) && (int'(code) - int'(FIRST_GLYPH) < FONT_CHARS);
		base = known ? (int'(code) - int'(FIRST_GLYPH)) * GLYPH_ROWS : 0;
		for (r = 0; r < GLYPH_ROWS; r++) begin
			px = known ? glyph_mem[base + r] : 8'h00;
			if (bold) px = px | (px >> 1);
			w.offset = cursor + OFFSET_W'(r * ROW_STRIDE);
			w.pixels = px;
			w.last   = 1'b0;
			pixel_queue.push_back(w);
			drawn++;
		end
		cursor = cursor + 1'b1;
		column++;
	endtask

	task automatic predict_item(input logic [1:0] cmd, input logic [IN_DATA_W-1:0] data);
		logic [9:0]   index;
		logic [7:0]   fbyte;
		logic [4:0]   row;
		logic [4:0]   col;
		logic [7:0]   code;
		logic [7:0]   lo;
		logic [7:0]   hi;
		pixel_write_t tail;
		index = data[9:0];
		fbyte = data[17:10];
		row   = data[22:18];
		col   = data[27:23];
		code  = data[35:28];
		lo    = data[43:36];
		hi    = data[51:44];
		drawn = 0;
		case (cmd)
			CMD_FONT: if (int'(index) < STORE_DEPTH) glyph_mem[index] = fbyte;
			CMD_START: begin
				cursor = OFFSET_W'((int'(row & 5'h18) << 8) + (int'(row & 5'h07) << 5) + int'(col));
				column = int'(col);
				bold   = 1'b0;
			end
			CMD_CHAR: if (column < ROW_CHARS) begin
				// first matching register wins when codes are shared
				if (code == codes[REG_BOLD_ON]) begin
					bold = 1'b1;
				end else if (code == codes[REG_BOLD_OFF]) begin
					bold = 1'b0;
				end else if (code == codes[REG_DECIMAL]) begin
					if (lo >= 8'd100) draw_glyph(CHAR_ZERO + lo / 8'd100);
					if (lo >= 8'd10) draw_glyph(CHAR_ZERO + (lo % 8'd100) / 8'd10);
					draw_glyph(CHAR_ZERO + lo % 8'd10);
				end else if (code == codes[REG_HEX_WORD]) begin
					draw_glyph(hex_digit(hi[7:4]));
					draw_glyph(hex_digit(hi[3:0]));
					draw_glyph(hex_digit(lo[7:4]));
					draw_glyph(hex_digit(lo[3:0]));
				end else if (code == codes[REG_HEX_BYTE]) begin
					draw_glyph(hex_digit(lo[7:4]));
					draw_glyph(hex_digit(lo[3:0]));
				end else begin
					draw_glyph(code);
				end
			end
			default: ;
		endcase
		// mark the final write of this item
		if (drawn > 0) begin
			tail = pixel_queue.pop_back();
			tail.last = 1'b1;
			pixel_queue.push_back(tail);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_write_t want;
		int           k;
		if (!arst_n) begin
			pixel_queue.delete();
			cursor = '0;
			column = ROW_CHARS;
			bold   = 1'b0;
			for (k = 0; k < REG_COUNT; k++) codes[k] = DEFAULT_CODES[8*k +: 8];
			pending <= 0;
		end else begin
			if (cfg_wen && cfg_addr <= REG_HEX_BYTE) codes[cfg_addr] = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (pixel_queue.size() == 0) begin
					log_mismatch($sformatf("unexpected write offset %h byte %h",
						m_axis_tdata[12:0], m_axis_tdata[20:13]));
				end else begin
					want = pixel_queue.pop_front();
					if (m_axis_tdata[12:0] != want.offset)
						log_mismatch($sformatf("offset %h, want %h",
							m_axis_tdata[12:0], want.offset));
					if (m_axis_tdata[20:13] != want.pixels)
						log_mismatch($sformatf("pixel byte %h, want %h",
							m_axis_tdata[20:13], want.pixels));
					if (m_axis_tlast !== want.last)
						log_mismatch($sformatf("last %b, want %b", m_axis_tlast, want.last));
				end
				checked++;
			end
			pending <= pixel_queue.size();
		end
	end

endmodule

### verif/tb_formatted_text_glyph_render.sv
// Testbench top for the glyph renderer: stimulus, stream idling and the verdict.
module tb_formatted_text_glyph_render;
	import ftgr_pkg::*;

	localparam int          ROW_CHARS     = 32;
	localparam int          FONT_CHARS    = 96;
	localparam int          FIRST_GLYPH   = 32;
	localparam int          REG_COUNT     = int'(REG_HEX_BYTE) + 1;
	localparam logic [39:0] RESET_CODES   = {8'd5, 8'd4, 8'd3, 8'd2, 8'd1};
	localparam logic [1:0]  CMD_UNUSED    = 2'd3;
	localparam logic [2:0]  REG_SPARE     = 3'd7;
	localparam logic [7:0]  CHAR_ZERO     = "0";
	localparam logic [7:0]  CHAR_A        = "a";
	// space, '!', 'W', 'x' and the top code of the font
	localparam logic [39:0] EXTRA_GLYPHS  = {8'd127, 8'd120, 8'd87, 8'd33, 8'd32};
	localparam int          EXTRA_COUNT   = 5;
	localparam int          LINE_ITEMS    = 10;
	localparam int          MAX_GAP       = 17;
	localparam int          SETTLE_CYCLES = 40;
	localparam int          LONG_HOLD     = 400;
	localparam int          CYCLE_LIMIT   = 1000000;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_wen       = 1'b0;
	logic [2:0]            cfg_addr      = '0;
	logic [7:0]            cfg_wdata     = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic [1:0]            s_axis_tuser  = CMD_FONT;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;

	int         mismatches;
	int         pending;
	int         hold_requests = 0;
	int         holds_done    = 0;
	int         cycle_count   = 0;
	bit         tx_quiet      = 1'b0;
	bit         rx_quiet      = 1'b0;
	logic [7:0] active_codes [REG_COUNT];

	formatted_text_glyph_render #(
		.ROW_CHARS (ROW_CHARS),
		.FONT_CHARS(FONT_CHARS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	ftgr_pixel_checker #(
		.ROW_CHARS    (ROW_CHARS),
		.FONT_CHARS   (FONT_CHARS),
		.DEFAULT_CODES(RESET_CODES)
	) u_pixel_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic send_item(input logic [1:0] kind, input logic [9:0] index,
		input logic [7:0] fbyte, input logic [4:0] row, input logic [4:0] col,
		input logic [7:0] code, input logic [7:0] lo, input logic [7:0] hi);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {4'b0, hi, lo, code, col, row, fbyte, index};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_font(input logic [9:0] index, input logic [7:0] fbyte);
		send_item(CMD_FONT, index, fbyte, '0, '0, '0, '0, '0);
	endtask

	task automatic send_start(input logic [4:0] row, input logic [4:0] col);
		send_item(CMD_START, '0, '0, row, col, '0, '0, '0);
	endtask

	task automatic send_char(input logic [7:0] code, input logic [7:0] lo, input logic [7:0] hi);
		send_item(CMD_CHAR, '0, '0, '0, '0, code, lo, hi);
	endtask

	// Write every row of one glyph with random pixels.
	task automatic fill_glyph(input logic [7:0] code);
		int r;
		for (r = 0; r < GLYPH_ROWS; r++)
			send_font(10'((int'(code) - FIRST_GLYPH) * GLYPH_ROWS + r),
				8'($urandom_range(0, 255)));
	endtask

	// A code whose glyph was written: digits, hex letters or one of the extras.
	function automatic logic [7:0] pick_glyph();
		int k;
		k = $urandom_range(0, 15 + EXTRA_COUNT);
		if (k < 10) return CHAR_ZERO + 8'(k);
		if (k < 16) return CHAR_A + 8'(k - 10);
		return EXTRA_GLYPHS[8*(k - 16) +: 8];
	endfunction

	task automatic send_random_char();
		int         pick;
		logic [7:0] code;
		pick = $urandom_range(0, 9);
		if (pick < 4) code = active_codes[$urandom_range(0, REG_COUNT - 1)];
		else if (pick < 8) code = pick_glyph();
		else if ($urandom_range(0, 1)) code = 8'($urandom_range(0, FIRST_GLYPH - 1));
		else code = 8'($urandom_range(FIRST_GLYPH + FONT_CHARS, 255));
		send_char(code, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	// Mostly whole lines: a start followed by characters and format codes.
	task automatic run_lines(input int count);
		int sent;
		int roll;
		int len;
		int k;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 7) == 0) tx_quiet = !tx_quiet;
			roll = $urandom_range(0, 99);
			if (roll < 75) begin
				send_start(roll < 6 ? 5'($urandom_range(24, 31)) : 5'($urandom_range(0, 23)),
					$urandom_range(0, 1) ? 5'($urandom_range(0, 15)) : 5'($urandom_range(0, 31)));
				len = $urandom_range(1, 9);
				for (k = 0; k < len; k++) send_random_char();
				sent += len + 1;
			end else if (roll < 87) begin
				send_font(10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
				sent++;
			end else if (roll < 93) begin
				send_item(CMD_UNUSED, 10'($urandom), 8'($urandom), 5'($urandom), 5'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom));
			end else begin
				send_random_char();
				sent++;
			end
		end
	endtask

	// Hold off input until every expected write is out and the block is quiet.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_codes(input logic [39:0] codes);
		int r;
		for (r = int'(REG_BOLD_ON); r <= int'(REG_HEX_BYTE); r++) begin
			cfg_wen   <= 1'b1;
			cfg_addr  <= 3'(r);
			cfg_wdata <= codes[8*r +: 8];
			active_codes[r] = codes[8*r +: 8];
			@(posedge clk);
		end
		cfg_wen <= 1'b0;
	endtask

	// Output side: random backpressure, quiet stretches and one long hold.
	initial begin
		int gap;
		int taken;
		taken = 0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (holds_done < hold_requests) begin
				gap = LONG_HOLD;
				holds_done++;
			end else begin
				gap = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
			taken++;
			if (taken % 48 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int i;
		for (i = 0; i < REG_COUNT; i++) active_codes[i] = RESET_CODES[8*i +: 8];
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// write only the glyphs that characters below draw; others stay unread
		for (i = 0; i < 10; i++) fill_glyph(CHAR_ZERO + 8'(i));
		for (i = 0; i < 6; i++) fill_glyph(CHAR_A + 8'(i));
		for (i = 0; i < EXTRA_COUNT; i++) fill_glyph(EXTRA_GLYPHS[8*i +: 8]);

		// directed: font edges, blank codes, bold, every format at its extremes
		send_start(5'd0, 5'd0);
		send_char(8'd32, 8'h00, 8'h00);
		send_char(8'd127, 8'h00, 8'h00);
		send_char(8'd128, 8'h00, 8'h00);
		send_char(8'd31, 8'h00, 8'h00);
		send_char(8'hFF, 8'h00, 8'h00);
		send_char(active_codes[REG_BOLD_ON], 8'h00, 8'h00);
		send_char(8'h57, 8'h00, 8'h00);
		send_char(active_codes[REG_BOLD_OFF], 8'h00, 8'h00);
		send_char(active_codes[REG_DECIMAL], 8'd0, 8'hFF);
		send_char(active_codes[REG_DECIMAL], 8'd9, 8'h00);
		send_char(active_codes[REG_DECIMAL], 8'd10, 8'h00);
		send_char(active_codes[REG_DECIMAL], 8'd105, 8'h00);
		send_char(active_codes[REG_DECIMAL], 8'd255, 8'h00);
		send_char(active_codes[REG_HEX_WORD], 8'h5A, 8'hA5);
		send_char(active_codes[REG_HEX_BYTE], 8'h0F, 8'h00);
		send_char(active_codes[REG_HEX_WORD], 8'hFF, 8'hFF);
		send_char(active_codes[REG_HEX_BYTE], 8'hF0, 8'h00);
		send_char(active_codes[REG_DECIMAL], 8'd99, 8'h00);
		// row past the screen, hex word cut at the row end, then a closed line
		send_start(5'd31, 5'd30);
		send_char(active_codes[REG_HEX_WORD], 8'h34, 8'h12);
		send_char(8'h78, 8'h00, 8'h00);
		send_char(active_codes[REG_BOLD_ON], 8'h00, 8'h00);
		send_font(10'd1023, 8'hFF);
		send_font(10'd768, 8'hFF);
		send_item(CMD_UNUSED, 10'h3FF, 8'hFF, 5'h1F, 5'h1F, 8'hFF, 8'hFF, 8'hFF);
		send_font(10'd0, 8'h81);
		send_start(5'd23, 5'd31);
		send_char(8'd32, 8'h00, 8'h00);
		send_char(8'd33, 8'h00, 8'h00);

		run_lines(LINE_ITEMS);
		drain();

		// bold on at zero, bold off at the top code
		program_codes({8'h80, 8'h7F, 8'h20, 8'hFF, 8'h00});
		run_lines(LINE_ITEMS);
		drain();

		// every code the same: bold on shadows the rest; stall the output meanwhile
		program_codes({5{8'hFF}});
		hold_requests++;
		run_lines(LINE_ITEMS);
		drain();

		// pairs of shared codes, after a write to an index with no register behind it
		cfg_wen   <= 1'b1;
		cfg_addr  <= REG_SPARE;
		cfg_wdata <= 8'($urandom);
		@(posedge clk);
		program_codes({8'h43, 8'h43, 8'h42, 8'h42, 8'h41});
		run_lines(LINE_ITEMS);
		drain();

		program_codes({8'($urandom), $urandom});
		run_lines(LINE_ITEMS);
		drain();

		if (mismatches == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/ftgr_pkg.sv
rtl/ftgr_ctrl.sv
rtl/ftgr_datapath.sv
rtl/formatted_text_glyph_render.sv
verif/ftgr_pixel_checker.sv
verif/tb_formatted_text_glyph_render.sv
